// File: rtl/lrukv_pkg.sv
package lrukv_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int          CAP_BITS  = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch request word, start key scan
        logic update;      // apply write / recency update for latched request
        logic read_value;  // load value of hit entry into read register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;   // last entry compared this cycle
        logic is_get;      // latched request is a lookup
    } t_dp_status;

endpackage

// File: rtl/lrukv_dp.sv
module lrukv_dp
    import lrukv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctl_cmd                     i_cmd,
    output t_dp_status                   o_status,
    input  logic                         i_op,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_cfg_wr,
    input  logic [CAP_BITS-1:0]          i_cfg_data,
    output logic                         o_hit,
    output logic signed [VALUE_BITS-1:0] o_read_value
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);

    // configuration
    logic [CAP_BITS-1:0] r_cap;

    // latched request
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // entry state
    logic [KEY_BITS-1:0]   r_key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] r_val_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [IW-1:0]         r_rank [ENTRIES];
    logic [UW-1:0]         r_used;

    // scan pipeline: issue stage reads key memory, check stage compares
    logic                  r_scan_on;
    logic [IW-1:0]         r_scan_addr;
    logic                  r_chk_on;
    logic                  r_chk_last;
    logic [IW-1:0]         r_chk_idx;
    logic                  r_chk_valid;
    logic [IW-1:0]         r_chk_rank;
    logic [KEY_BITS-1:0]   r_key_q;

    // scan results
    logic                  r_hit;
    logic [IW-1:0]         r_hit_idx;
    logic [IW-1:0]         r_hit_rank;
    logic                  r_free_found;
    logic [IW-1:0]         r_free_idx;
    logic                  r_vict_found;
    logic [IW-1:0]         r_vict_idx;
    logic [IW-1:0]         r_vict_rank;

    logic [VALUE_BITS-1:0] r_val_q;

    // update controls
    logic [UW-1:0] eff_cap;
    logic          room;
    logic [IW-1:0] tgt_idx;
    logic [IW-1:0] old_rank;
    logic          age_all;
    logic          do_touch;
    logic          wr_key;
    logic          wr_val;
    logic          set_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr) begin
            r_cap <= i_cfg_data;
        end
    end

    // capacity zero acts as one, large values saturate
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = UW'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            eff_cap = UW'(ENTRIES);
        end else begin
            eff_cap = UW'(r_cap);
        end
    end

    assign room = (r_used < eff_cap);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on    <= 1'b0;
            r_scan_addr  <= '0;
            r_chk_on     <= 1'b0;
            r_chk_last   <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_vict_found <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_scan_on    <= 1'b1;
                r_scan_addr  <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_vict_found <= 1'b0;
            end else if (r_scan_on) begin
                r_scan_addr <= r_scan_addr + 1'b1;
                if (r_scan_addr == IW'(ENTRIES - 1)) begin
                    r_scan_on <= 1'b0;
                end
            end
            r_chk_on   <= r_scan_on && !i_cmd.capture;
            r_chk_last <= (r_scan_addr == IW'(ENTRIES - 1));

            if (r_chk_on) begin
                if (r_chk_valid && r_key_q == r_key && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!r_chk_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
                if (r_chk_valid && (!r_vict_found || r_chk_rank > r_vict_rank)) begin
                    r_vict_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_scan_on) begin
            r_chk_idx   <= r_scan_addr;
            r_chk_valid <= r_valid[r_scan_addr];
            r_chk_rank  <= r_rank[r_scan_addr];
        end
        if (r_chk_on) begin
            if (r_chk_valid && r_key_q == r_key && !r_hit) begin
                r_hit_idx  <= r_chk_idx;
                r_hit_rank <= r_chk_rank;
            end
            if (!r_chk_valid && !r_free_found) begin
                r_free_idx <= r_chk_idx;
            end
            if (r_chk_valid && (!r_vict_found || r_chk_rank > r_vict_rank)) begin
                r_vict_idx  <= r_chk_idx;
                r_vict_rank <= r_chk_rank;
            end
        end
    end

    always_comb begin
        tgt_idx   = r_hit_idx;
        old_rank  = r_hit_rank;
        age_all   = 1'b0;
        do_touch  = 1'b0;
        wr_key    = 1'b0;
        wr_val    = 1'b0;
        set_valid = 1'b0;
        if (i_cmd.update) begin
            if (r_hit) begin
                do_touch = 1'b1;
                wr_val   = (r_op == OP_PUT);
            end else if (r_op == OP_PUT) begin
                if (room) begin
                    // fill a free slot, every other live entry ages
                    tgt_idx   = r_free_idx;
                    age_all   = 1'b1;
                    set_valid = 1'b1;
                    do_touch  = 1'b1;
                    wr_key    = 1'b1;
                    wr_val    = 1'b1;
                end else if (r_vict_found) begin
                    tgt_idx  = r_vict_idx;
                    old_rank = r_vict_rank;
                    do_touch = 1'b1;
                    wr_key   = 1'b1;
                    wr_val   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            r_key_mem[tgt_idx] <= r_key;
        end
        if (r_scan_on) begin
            r_key_q <= r_key_mem[r_scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_val) begin
            r_val_mem[tgt_idx] <= r_value;
        end
        if (i_cmd.read_value) begin
            r_val_q <= r_val_mem[r_hit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (set_valid) begin
                r_valid[tgt_idx] <= 1'b1;
                r_used           <= r_used + 1'b1;
            end
            if (do_touch) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == tgt_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (age_all || r_rank[i] < old_rank)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    assign o_status.scan_done = r_chk_on && r_chk_last;
    assign o_status.is_get    = (r_op == OP_GET);

    assign o_hit        = r_hit;
    assign o_read_value = r_hit ? r_val_q : '0;

    a_used_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("used count out of step with valid bits");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= ENTRIES)
        else $error("used count above entry count");

    a_done_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.scan_done |-> !r_scan_on)
        else $error("scan finished while still issuing");

    a_hit_is_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_hit) |-> r_valid[r_hit_idx])
        else $error("hit on an invalid entry");

endmodule

// File: rtl/lrukv_ctrl.sv
module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    output logic       o_strobe,
    output t_ctl_cmd   o_cmd,
    input  t_dp_status i_status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_RESP   = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.update     = 1'b0;
        o_cmd.read_value = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.update     = 1'b1;
                o_cmd.read_value = i_status.is_get;
                n_state          = i_status.is_get ? ST_RESP : ST_IDLE;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = (r_state == ST_RESP);

    a_resp_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |-> ($past(r_state) == ST_DECIDE))
        else $error("response without a decide cycle");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.scan_done) |=> (r_state == ST_DECIDE))
        else $error("scan completion not followed by decide");

    a_done_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.scan_done |-> (r_state == ST_SCAN))
        else $error("scan completion outside scan state");

endmodule

// File: rtl/lru_key_value_cache.sv
// A lookup word returns its result after the key scan and the decide state, in the response state.
// A new word is taken only from idle, once the previous word has finished;
// the key scan reads one entry per cycle through the single key memory port.
// The result strobe is high for one cycle and cannot be stalled by the receiver.
// Reset (synchronous, active low) clears all valid bits, ranks and the used count;
// capacity returns to 16. Key and value memories are not cleared.
module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic signed [VALUE_BITS-1:0] o_read_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CAP_BITS-1:0]          i_cfg_data
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    lrukv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd),
        .i_status (status)
    );

    lrukv_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_cfg_wr     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

endmodule

// File: bench/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lrukv_pkg::*;

    localparam int SLOTS       = DEF_ENTRIES;
    localparam int KB          = DEF_KEY_BITS;
    localparam int VB          = DEF_VALUE_BITS;
    localparam int SETTLE      = SLOTS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_MAX    = 24;

    typedef struct {
        logic                 hit;
        logic signed [VB-1:0] rd;
    } t_lookup;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic                 i_op         = OP_GET;
    logic [KB-1:0]        i_key        = '0;
    logic signed [VB-1:0] i_value      = '0;
    logic                 o_strobe;
    logic                 o_hit;
    logic signed [VB-1:0] o_read_value;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_BITS-1:0]  i_cfg_data   = '0;

    // shadow copy of the cache
    logic [KB-1:0]        slot_key   [SLOTS];
    logic signed [VB-1:0] slot_val   [SLOTS];
    bit                   slot_valid [SLOTS];
    int unsigned          slot_rank  [SLOTS];
    int unsigned          used_slots;
    logic [CAP_BITS-1:0]  cap_reg;

    t_lookup     pending_lookups[$];
    int          err_count   = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on     = 1'b1;
    logic [KB-1:0] key_pool[POOL_MAX];

    lru_key_value_cache DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_lru_key_value_cache: done, errors");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (i_rst_n && o_strobe) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result word hit=%0b value=%0d",
                         $time, o_hit, o_read_value);
                err_count++;
            end else begin
                exp_r = pending_lookups.pop_front();
                if (o_hit !== exp_r.hit) begin
                    $display("%0t: hit mismatch, expected %0b, got %0b",
                             $time, exp_r.hit, o_hit);
                    err_count++;
                end
                if (o_read_value !== exp_r.rd) begin
                    $display("%0t: read_value mismatch, expected %0d, got %0d",
                             $time, exp_r.rd, o_read_value);
                    err_count++;
                end
            end
        end
    end

    function automatic void clear_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]   = '0;
            slot_val[i]   = '0;
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
        end
        used_slots = 0;
        cap_reg    = CAP_RESET;
    endfunction

    function automatic int unsigned usable_slots();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > SLOTS)
            return SLOTS;
        return cap_reg;
    endfunction

    // entry idx becomes most recent; newer entries age by one
    function automatic void move_to_front(int idx, int unsigned old_rank);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != idx && slot_rank[i] < old_rank)
                slot_rank[i]++;
        slot_rank[idx] = 0;
    endfunction

    function automatic void predict_word(logic op, logic [KB-1:0] key,
                                         logic signed [VB-1:0] value);
        int          pos;
        int          victim;
        int unsigned oldest;
        bit          placed;
        t_lookup     r;
        pos    = -1;
        victim = -1;
        oldest = 0;
        placed = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (pos < 0 && slot_valid[i] && slot_key[i] == key)
                pos = i;
        if (op == OP_GET) begin
            if (pos >= 0) begin
                r.hit = 1'b1;
                r.rd  = slot_val[pos];
                move_to_front(pos, slot_rank[pos]);
            end else begin
                r.hit = 1'b0;
                r.rd  = '0;
            end
            pending_lookups.push_back(r);
        end else if (pos >= 0) begin
            slot_val[pos] = value;
            move_to_front(pos, slot_rank[pos]);
        end else if (used_slots < usable_slots()) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!placed && !slot_valid[i]) begin
                    placed        = 1'b1;
                    slot_valid[i] = 1'b1;
                    slot_key[i]   = key;
                    slot_val[i]   = value;
                    used_slots++;
                    move_to_front(i, SLOTS);
                end
            end
        end else begin
            // evict least recent
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_valid[i] && (victim < 0 || slot_rank[i] > oldest)) begin
                    victim = i;
                    oldest = slot_rank[i];
                end
            end
            if (victim >= 0) begin
                slot_key[victim] = key;
                slot_val[victim] = value;
                move_to_front(victim, oldest);
            end
        end
    endfunction

    // start stays high after acceptance so back-to-back words need no toggle
    task automatic send_word(input logic op, input logic [KB-1:0] key,
                             input logic signed [VB-1:0] value);
        if (gaps_on && $urandom_range(99) < 28) begin
            start <= 1'b0;
            // let the previous word finish so the gap is real idle time
            do @(posedge i_clk); while (busy);
            repeat ($urandom_range(0, 49)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        predict_word(op, key, value);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        // stores give no result word; let the last one finish
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = cap;
    endtask

    task automatic test_lookup_store_basics();
        send_word(OP_GET, 16'h0000, 32'sd77);        // miss on empty cache
        send_word(OP_PUT, 16'h0000, 32'sh8000_0000);
        send_word(OP_PUT, 16'hFFFF, 32'sh7FFF_FFFF);
        send_word(OP_GET, 16'h0000, '0);
        send_word(OP_GET, 16'hFFFF, '1);
        send_word(OP_PUT, 16'h0000, -32'sd1);        // update in place
        send_word(OP_GET, 16'h0000, '0);
        send_word(OP_GET, 16'h1234, '0);
    endtask

    task automatic test_capacity_bounds();
        // zero acts as one; two entries already held, so puts replace the oldest
        set_capacity(5'd0);
        send_word(OP_PUT, 16'h0005, 32'sd5);
        send_word(OP_PUT, 16'h0006, 32'sd6);
        send_word(OP_GET, 16'h0005, '0);
        send_word(OP_GET, 16'h0006, '0);
        send_word(OP_GET, 16'hFFFF, '0);
        // above the entry count saturates
        set_capacity(5'd31);
        send_word(OP_PUT, 16'h00A0, 32'sh5555_AAAA);
        send_word(OP_PUT, 16'h00A1, 32'shAAAA_5555);
        send_word(OP_PUT, 16'h00A2, 32'sd0);
        send_word(OP_GET, 16'h00A1, '0);
        send_word(OP_GET, 16'h0006, '0);
        set_capacity(5'd1);
        send_word(OP_PUT, 16'h00A3, 32'sd3);
        send_word(OP_GET, 16'h00A0, '0);
        send_word(OP_GET, 16'h00A3, '0);
    endtask

    task automatic test_random_traffic();
        logic [CAP_BITS-1:0] caps[6];
        int                  pool_n;
        logic [KB-1:0]       key;
        caps = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0, 5'd8};
        caps[5] = CAP_BITS'($urandom_range(2, 15));
        for (int ph = 0; ph < 6; ph++) begin
            set_capacity(caps[ph]);
            pool_n = usable_slots() + $urandom_range(0, 4);
            for (int k = 0; k < POOL_MAX; k++)
                key_pool[k] = KB'($urandom_range(0, 16'hFFFF));
            gaps_on = (ph != 2);
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(99) < 8)
                    key = KB'($urandom_range(0, 16'hFFFF));
                else
                    key = key_pool[$urandom_range(0, pool_n - 1)];
                send_word($urandom_range(0, 1) ? OP_PUT : OP_GET, key, $urandom);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        clear_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_lookup_store_basics();
        test_capacity_bounds();
        test_random_traffic();
        drain();
        if (err_count == 0)
            $display("tb_lru_key_value_cache: done, clean");
        else
            $display("tb_lru_key_value_cache: done, errors");
        $finish;
    end

endmodule
